@@ sv/i2cmbe_pkg.sv @@
// Package for the I2C master byte engine.
// Holds the bus phase type, command mode codes and word bit positions.
// No dependencies.
package i2cmbe_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_START_C = 4'd3,
    PH_WB_LO   = 4'd4,
    PH_WB_HI   = 4'd5,
    PH_RB_LO   = 4'd6,
    PH_RB_HI   = 4'd7,
    PH_STOP_A  = 4'd8,
    PH_STOP_B  = 4'd9,
    PH_STOP_C  = 4'd10
  } phase_e;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam int unsigned HALF_PERIOD_W     = 16;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
  localparam int unsigned BYTE_BITS         = 8;

  // pin word: bit0 SCL, bit1 SDA, bit2 drive
  localparam logic [2:0] PINS_IDLE_HIGH = 3'b111;
  localparam logic [2:0] PINS_SCL_HIGH  = 3'b101;
  localparam logic [2:0] PINS_LOW       = 3'b100;
  localparam logic [2:0] PINS_REL_LO    = 3'b010;
  localparam logic [2:0] PINS_REL_HI    = 3'b011;
  localparam logic [2:0] PINS_REL_MASK  = 3'b110;

  // result word bit positions
  localparam int unsigned OUT_BUSY = 3;
  localparam int unsigned OUT_DONE = 4;

  typedef struct packed {
    logic       with_start;
    logic       with_stop;
    logic       send_ack;
  } flags_t;

endpackage

@@ sv/i2c_master_byte_engine_unit.sv @@
// I2C master byte engine, top level.
// One word in per bus tick, one result word out; uses i2cmbe_pkg.
//
// Each input word is one bus tick and is taken in every cycle while the result
// register is empty or being drained; its result comes from a single result
// register. A command (write byte with optional start and stop, read byte with
// ACK/NACK and optional stop, or stop only) runs as a sequence of bus phases of
// half_period_ticks words each, counted by a DELAY_COUNTER_BITS wide delay
// counter that saturates the half period at its maximum; a zero half period
// counts as one tick. A command is taken only on an idle tick and the tick
// after its done pulse is idle again. The user must write the half period via
// cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
module i2c_master_byte_engine_unit #(
  parameter int unsigned DELAY_COUNTER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] tx_byte, [8] with_start, [9] with_stop, [10] send_ack, [11] sda_in
  input  logic [15:0] s_axis_tdata,
  // [0] cmd_valid, [2:1] mode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_received
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned LW = (DELAY_COUNTER_BITS > i2cmbe_pkg::HALF_PERIOD_W) ?
                               DELAY_COUNTER_BITS : i2cmbe_pkg::HALF_PERIOD_W;
  localparam logic [LW-1:0] CMAX = LW'((64'd1 << DELAY_COUNTER_BITS) - 64'd1);

  logic [15:0]                   hp_q;
  i2cmbe_pkg::phase_e            ph_q, ph_d;
  logic [3:0]                    bi_q, bi_d;
  logic [7:0]                    sr_q, sr_d;
  logic [DELAY_COUNTER_BITS-1:0] tc_q, tc_d;
  logic [1:0]                    am_q, am_d;
  i2cmbe_pkg::flags_t            fl_q, fl_d;
  logic [2:0]                    pin_q, pin_d;
  logic                          ack_q, ack_d;
  logic [7:0]                    rx_q, rx_d;
  logic                          out_valid_q;
  logic [15:0]                   out_data_q, out_data_d;

  logic          in_acc;
  logic          cmd_valid, sda_in;
  logic [1:0]    mode;
  logic [LW-1:0] hp_ext, limit;
  logic [LW:0]   tc_next;
  logic          tick_end;
  logic [2:0]    pins;
  logic          busy, done, wbit;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign cmd_valid = s_axis_tuser[0];
  assign mode      = s_axis_tuser[2:1];
  assign sda_in    = s_axis_tdata[11];

  assign hp_ext = LW'(hp_q);
  always_comb begin
    if (hp_q == 16'd0) begin
      limit = LW'(1);
    end else if (hp_ext > CMAX) begin
      limit = CMAX;
    end else begin
      limit = hp_ext;
    end
  end

  always_comb begin
    ph_d  = ph_q;
    bi_d  = bi_q;
    sr_d  = sr_q;
    tc_d  = tc_q;
    am_d  = am_q;
    fl_d  = fl_q;
    pin_d = pin_q;
    ack_d = ack_q;
    rx_d  = rx_q;
    busy  = 1'b0;
    done  = 1'b0;

    if (ph_q == i2cmbe_pkg::PH_IDLE && cmd_valid && mode != i2cmbe_pkg::MODE_NONE) begin
      am_d = mode;
      fl_d = '{with_start: s_axis_tdata[8], with_stop: s_axis_tdata[9],
               send_ack: s_axis_tdata[10]};
      sr_d = (mode == i2cmbe_pkg::MODE_WRITE) ? s_axis_tdata[7:0] : 8'd0;
      bi_d = 4'd0;
      tc_d = '0;
      if (mode == i2cmbe_pkg::MODE_WRITE) begin
        ph_d = s_axis_tdata[8] ? i2cmbe_pkg::PH_START_A : i2cmbe_pkg::PH_WB_LO;
      end else if (mode == i2cmbe_pkg::MODE_READ) begin
        ph_d = i2cmbe_pkg::PH_RB_LO;
      end else begin
        ph_d = i2cmbe_pkg::PH_STOP_A;
      end
    end

    wbit = (bi_d < 4'(i2cmbe_pkg::BYTE_BITS)) ? sr_d[7] : !fl_d.send_ack;
    case (ph_d)
      i2cmbe_pkg::PH_START_A: pins = i2cmbe_pkg::PINS_IDLE_HIGH;
      i2cmbe_pkg::PH_START_B: pins = i2cmbe_pkg::PINS_SCL_HIGH;
      i2cmbe_pkg::PH_START_C: pins = i2cmbe_pkg::PINS_LOW;
      i2cmbe_pkg::PH_WB_LO:   pins = {1'b1, wbit, 1'b0};
      i2cmbe_pkg::PH_WB_HI:   pins = {1'b1, wbit, 1'b1};
      i2cmbe_pkg::PH_RB_LO:   pins = i2cmbe_pkg::PINS_REL_LO;
      i2cmbe_pkg::PH_RB_HI:   pins = i2cmbe_pkg::PINS_REL_HI;
      i2cmbe_pkg::PH_STOP_A:  pins = i2cmbe_pkg::PINS_LOW;
      i2cmbe_pkg::PH_STOP_B:  pins = i2cmbe_pkg::PINS_SCL_HIGH;
      i2cmbe_pkg::PH_STOP_C:  pins = i2cmbe_pkg::PINS_IDLE_HIGH;
      default:                pins = pin_q;
    endcase

    tc_next  = {1'b0, LW'(tc_d)} + {{LW{1'b0}}, 1'b1};
    tick_end = tc_next >= {1'b0, limit};

    if (ph_d != i2cmbe_pkg::PH_IDLE) begin
      busy = 1'b1;
      if (tick_end) begin
        tc_d = '0;
        case (ph_d)
          i2cmbe_pkg::PH_START_A: ph_d = i2cmbe_pkg::PH_START_B;
          i2cmbe_pkg::PH_START_B: ph_d = i2cmbe_pkg::PH_START_C;
          i2cmbe_pkg::PH_START_C: ph_d = i2cmbe_pkg::PH_WB_LO;
          i2cmbe_pkg::PH_WB_LO:   ph_d = i2cmbe_pkg::PH_WB_HI;
          i2cmbe_pkg::PH_RB_LO:   ph_d = i2cmbe_pkg::PH_RB_HI;
          i2cmbe_pkg::PH_STOP_A:  ph_d = i2cmbe_pkg::PH_STOP_B;
          i2cmbe_pkg::PH_STOP_B:  ph_d = i2cmbe_pkg::PH_STOP_C;
          i2cmbe_pkg::PH_STOP_C: begin
            done  = 1'b1;
            pin_d = pins;
            ph_d  = i2cmbe_pkg::PH_IDLE;
          end
          i2cmbe_pkg::PH_WB_HI: begin
            if (bi_d < 4'(i2cmbe_pkg::BYTE_BITS)) begin
              sr_d = {sr_d[6:0], 1'b0};
              bi_d = bi_d + 4'd1;
              ph_d = (bi_d == 4'(i2cmbe_pkg::BYTE_BITS)) ? i2cmbe_pkg::PH_RB_LO :
                                                         i2cmbe_pkg::PH_WB_LO;
            end else if (fl_d.with_stop) begin
              ph_d = i2cmbe_pkg::PH_STOP_A;
            end else begin
              done  = 1'b1;
              pin_d = pins & i2cmbe_pkg::PINS_REL_MASK;
              ph_d  = i2cmbe_pkg::PH_IDLE;
            end
          end
          i2cmbe_pkg::PH_RB_HI: begin
            if (bi_d < 4'(i2cmbe_pkg::BYTE_BITS)) begin
              sr_d = {sr_d[6:0], sda_in};
              bi_d = bi_d + 4'd1;
              ph_d = (bi_d == 4'(i2cmbe_pkg::BYTE_BITS)) ? i2cmbe_pkg::PH_WB_LO :
                                                         i2cmbe_pkg::PH_RB_LO;
            end else begin
              ack_d = !sda_in;
              if (fl_d.with_stop) begin
                ph_d = i2cmbe_pkg::PH_STOP_A;
              end else begin
                done  = 1'b1;
                pin_d = i2cmbe_pkg::PINS_REL_MASK;
                ph_d  = i2cmbe_pkg::PH_IDLE;
              end
            end
          end
          default: ph_d = i2cmbe_pkg::PH_IDLE;
        endcase
        if (done && am_d == i2cmbe_pkg::MODE_READ) begin
          rx_d = sr_d;
        end
      end else begin
        tc_d = tc_next[DELAY_COUNTER_BITS-1:0];
      end
    end

    out_data_d = {2'b00, ack_d, rx_d, done, busy, pins[2], pins[1], pins[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q        <= i2cmbe_pkg::HALF_PERIOD_RESET;
      ph_q        <= i2cmbe_pkg::PH_IDLE;
      bi_q        <= 4'd0;
      sr_q        <= 8'd0;
      tc_q        <= '0;
      am_q        <= i2cmbe_pkg::MODE_WRITE;
      fl_q        <= '0;
      pin_q       <= i2cmbe_pkg::PINS_IDLE_HIGH;
      ack_q       <= 1'b0;
      rx_q        <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hp_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        ph_q        <= ph_d;
        bi_q        <= bi_d;
        sr_q        <= sr_d;
        tc_q        <= tc_d;
        am_q        <= am_d;
        fl_q        <= fl_d;
        pin_q       <= pin_d;
        ack_q       <= ack_d;
        rx_q        <= rx_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[i2cmbe_pkg::OUT_DONE] |-> out_data_q[i2cmbe_pkg::OUT_BUSY])
    else $error("done without busy");

  a_idle_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ph_q == i2cmbe_pkg::PH_IDLE && !cmd_valid
    |=> !out_data_q[i2cmbe_pkg::OUT_BUSY])
    else $error("busy reported on idle tick");

  a_idle_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == i2cmbe_pkg::PH_IDLE |-> tc_q == '0)
    else $error("delay counter running while idle");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bi_q <= 4'(i2cmbe_pkg::BYTE_BITS))
    else $error("bit index out of range");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_valid_q)
    else $error("input stalled with empty result register");

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for i2c_master_byte_engine_unit: predicts pins, busy, done,
// received byte and ACK flag for every bus tick word and compares each result word.
// Depends on i2cmbe_pkg and the engine top level only.
module tb_top;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int SDA_LOW     = 0;
  localparam int SDA_HIGH    = 1;
  localparam int SDA_RAND    = 2;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       with_start;
    logic       with_stop;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] rx;
    logic       done;
    logic       busy;
    logic       drive;
    logic       sda;
    logic       scl;
  } bus_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  i2c_master_byte_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // engine shadow state
  i2cmbe_pkg::phase_e ph = i2cmbe_pkg::PH_IDLE;
  logic [3:0]         bidx = '0;
  logic [7:0]         shreg = '0;
  logic [15:0]        tcnt = '0;
  logic [1:0]         amode = i2cmbe_pkg::MODE_WRITE;
  i2cmbe_pkg::flags_t cflags = '0;
  logic [2:0]         pins_q = i2cmbe_pkg::PINS_IDLE_HIGH;
  logic               ackq = 1'b0;
  logic [7:0]         rxq = '0;
  logic [15:0]        hp = i2cmbe_pkg::HALF_PERIOD_RESET;

  bus_res_t pending_bus_q[$];

  int  cycles = 0;
  int  words_sent = 0;
  int  cmds_taken = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  stall_left = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;

  function automatic logic [2:0] phase_pins();
    logic b;
    case (ph)
      i2cmbe_pkg::PH_START_A, i2cmbe_pkg::PH_STOP_C: return i2cmbe_pkg::PINS_IDLE_HIGH;
      i2cmbe_pkg::PH_START_B, i2cmbe_pkg::PH_STOP_B: return i2cmbe_pkg::PINS_SCL_HIGH;
      i2cmbe_pkg::PH_START_C, i2cmbe_pkg::PH_STOP_A: return i2cmbe_pkg::PINS_LOW;
      i2cmbe_pkg::PH_WB_LO, i2cmbe_pkg::PH_WB_HI: begin
        b = (bidx < i2cmbe_pkg::BYTE_BITS) ? shreg[7] : ~cflags.send_ack;
        return {1'b1, b, ph == i2cmbe_pkg::PH_WB_HI};
      end
      i2cmbe_pkg::PH_RB_LO: return i2cmbe_pkg::PINS_REL_LO;
      i2cmbe_pkg::PH_RB_HI: return i2cmbe_pkg::PINS_REL_HI;
      default: return pins_q;
    endcase
  endfunction

  task automatic end_cmd(input logic [2:0] p);
    if (amode == i2cmbe_pkg::MODE_READ) rxq = shreg;
    pins_q = p;
    ph = i2cmbe_pkg::PH_IDLE;
  endtask

  task automatic engine_tick(input tick_t w);
    logic [2:0]  p;
    logic        busy;
    logic        done;
    logic [16:0] lim;
    bus_res_t    r;
    busy = 1'b0;
    done = 1'b0;
    lim = (hp == 16'd0) ? 17'd1 : {1'b0, hp};
    if (ph == i2cmbe_pkg::PH_IDLE && w.cmd_valid && w.mode != i2cmbe_pkg::MODE_NONE) begin
      amode = w.mode;
      cflags.with_start = w.with_start;
      cflags.with_stop = w.with_stop;
      cflags.send_ack = w.send_ack;
      shreg = (w.mode == i2cmbe_pkg::MODE_WRITE) ? w.tx_byte : 8'd0;
      bidx = '0;
      tcnt = '0;
      cmds_taken++;
      if (w.mode == i2cmbe_pkg::MODE_WRITE)
        ph = w.with_start ? i2cmbe_pkg::PH_START_A : i2cmbe_pkg::PH_WB_LO;
      else if (w.mode == i2cmbe_pkg::MODE_READ) ph = i2cmbe_pkg::PH_RB_LO;
      else ph = i2cmbe_pkg::PH_STOP_A;
    end
    p = phase_pins();
    if (ph != i2cmbe_pkg::PH_IDLE) begin
      busy = 1'b1;
      if ({1'b0, tcnt} + 17'd1 >= lim) begin
        tcnt = '0;
        case (ph)
          i2cmbe_pkg::PH_START_A: ph = i2cmbe_pkg::PH_START_B;
          i2cmbe_pkg::PH_START_B: ph = i2cmbe_pkg::PH_START_C;
          i2cmbe_pkg::PH_START_C: ph = i2cmbe_pkg::PH_WB_LO;
          i2cmbe_pkg::PH_WB_LO: ph = i2cmbe_pkg::PH_WB_HI;
          i2cmbe_pkg::PH_RB_LO: ph = i2cmbe_pkg::PH_RB_HI;
          i2cmbe_pkg::PH_STOP_A: ph = i2cmbe_pkg::PH_STOP_B;
          i2cmbe_pkg::PH_STOP_B: ph = i2cmbe_pkg::PH_STOP_C;
          i2cmbe_pkg::PH_STOP_C: begin
            end_cmd(p);
            done = 1'b1;
          end
          i2cmbe_pkg::PH_WB_HI: begin
            if (bidx < i2cmbe_pkg::BYTE_BITS) begin
              shreg = {shreg[6:0], 1'b0};
              bidx++;
              ph = (bidx == i2cmbe_pkg::BYTE_BITS) ? i2cmbe_pkg::PH_RB_LO :
                                                     i2cmbe_pkg::PH_WB_LO;
            end else if (cflags.with_stop) begin
              ph = i2cmbe_pkg::PH_STOP_A;
            end else begin
              end_cmd(p & i2cmbe_pkg::PINS_REL_MASK);
              done = 1'b1;
            end
          end
          i2cmbe_pkg::PH_RB_HI: begin
            if (bidx < i2cmbe_pkg::BYTE_BITS) begin
              shreg = {shreg[6:0], w.sda_in};
              bidx++;
              ph = (bidx == i2cmbe_pkg::BYTE_BITS) ? i2cmbe_pkg::PH_WB_LO :
                                                     i2cmbe_pkg::PH_RB_LO;
            end else begin
              ackq = ~w.sda_in;
              if (cflags.with_stop) begin
                ph = i2cmbe_pkg::PH_STOP_A;
              end else begin
                end_cmd(i2cmbe_pkg::PINS_REL_MASK);
                done = 1'b1;
              end
            end
          end
          default: ph = i2cmbe_pkg::PH_IDLE;
        endcase
      end else begin
        tcnt++;
      end
    end
    r.scl = p[0];
    r.sda = p[1];
    r.drive = p[2];
    r.busy = busy;
    r.done = done;
    r.rx = rxq;
    r.ack = ackq;
    pending_bus_q.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    if (!src_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input tick_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, w.sda_in, w.send_ack, w.with_stop, w.with_start, w.tx_byte};
    s_axis_tuser <= {w.mode, w.cmd_valid};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
    engine_tick(w);
  endtask

  function automatic logic pick_sda(input int sel);
    if (sel == SDA_LOW) return 1'b0;
    if (sel == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic tick_t noise_word(input bit offer, input int sda_sel);
    tick_t w;
    w = tick_t'($urandom);
    w.cmd_valid = offer ? 1'($urandom_range(0, 1)) : 1'b0;
    w.sda_in = pick_sda(sda_sel);
    return w;
  endfunction

  task automatic send_idle(input int n);
    repeat (n) send_word(noise_word(1'b0, SDA_RAND));
  endtask

  task automatic run_cmd(input logic [1:0] mode, input logic [7:0] tx, input logic st,
                         input logic sp, input logic ak, input int sda_sel, input bit noisy);
    tick_t w;
    w.cmd_valid = 1'b1;
    w.mode = mode;
    w.tx_byte = tx;
    w.with_start = st;
    w.with_stop = sp;
    w.send_ack = ak;
    w.sda_in = pick_sda(sda_sel);
    send_word(w);
    while (ph != i2cmbe_pkg::PH_IDLE) send_word(noise_word(noisy, sda_sel));
  endtask

  task automatic set_half_period(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_bus_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    hp = v;
  endtask

  task automatic check_field(input string name, input int e, input int g);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected 0x%0h got 0x%0h (result %0d)", name, e, g, results_seen);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (sink_idle && $urandom_range(0, 99) < 15) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 50);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    bus_res_t e;
    bus_res_t g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      g = bus_res_t'(m_axis_tdata[13:0]);
      if (pending_bus_q.size() == 0) begin
        check_field("unexpected word", 0, int'(g));
      end else begin
        e = pending_bus_q.pop_front();
        if (g.scl !== e.scl) check_field("scl_level", e.scl, g.scl);
        if (g.sda !== e.sda) check_field("sda_level", e.sda, g.sda);
        if (g.drive !== e.drive) check_field("sda_drive", e.drive, g.drive);
        if (g.busy !== e.busy) check_field("busy", e.busy, g.busy);
        if (g.done !== e.done) check_field("done", e.done, g.done);
        if (g.rx !== e.rx) check_field("rx_byte", e.rx, g.rx);
        if (g.ack !== e.ack) check_field("ack_received", e.ack, g.ack);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_bus_q.size());
      $display("FAIL i2c_master_byte_engine_unit");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_idle(4);
    run_cmd(i2cmbe_pkg::MODE_WRITE, 8'h5A, 1'b1, 1'b0, 1'b0, SDA_RAND, 1'b0);
    send_idle(3);
  endtask

  task automatic test_directed_cmds();
    set_half_period(16'd1);
    run_cmd(i2cmbe_pkg::MODE_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, SDA_LOW, 1'b0);
    run_cmd(i2cmbe_pkg::MODE_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, SDA_HIGH, 1'b0);
    send_idle(2);
    run_cmd(i2cmbe_pkg::MODE_WRITE, 8'hA5, 1'b0, 1'b1, 1'b1, SDA_RAND, 1'b1);
    run_cmd(i2cmbe_pkg::MODE_READ, 8'h3C, 1'b1, 1'b1, 1'b1, SDA_HIGH, 1'b0);
    run_cmd(i2cmbe_pkg::MODE_READ, 8'hC3, 1'b0, 1'b0, 1'b0, SDA_LOW, 1'b1);
    run_cmd(i2cmbe_pkg::MODE_STOP, 8'h00, 1'b1, 1'b0, 1'b1, SDA_RAND, 1'b1);
    run_cmd(i2cmbe_pkg::MODE_NONE, 8'hFF, 1'b1, 1'b1, 1'b1, SDA_RAND, 1'b0);
    run_cmd(i2cmbe_pkg::MODE_READ, 8'h00, 1'b0, 1'b1, 1'b0, SDA_RAND, 1'b1);
    send_idle(2);
  endtask

  task automatic test_zero_half_period();
    set_half_period(16'd0);
    run_cmd(i2cmbe_pkg::MODE_WRITE, 8'h81, 1'b1, 1'b1, 1'b0, SDA_RAND, 1'b1);
    run_cmd(i2cmbe_pkg::MODE_READ, 8'h00, 1'b0, 1'b0, 1'b1, SDA_RAND, 1'b1);
    set_half_period(16'd2);
    run_cmd(i2cmbe_pkg::MODE_WRITE, 8'h7E, 1'b0, 1'b1, 1'b0, SDA_RAND, 1'b1);
  endtask

  task automatic test_random_traffic();
    int       stop_at;
    int       k;
    int       r;
    logic [1:0] m;
    logic [15:0] hps[5];
    hps = '{16'd1, 16'd2, 16'd3, 16'($urandom_range(1, 7)), 16'd1};
    for (k = 0; k < 5; k++) begin
      set_half_period(hps[k]);
      src_idle = (k != 1);
      sink_idle = (k != 1);
      stop_at = words_sent + 50;
      while (words_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_idle($urandom_range(1, 4));
        end else begin
          m = ($urandom_range(0, 15) == 0) ? i2cmbe_pkg::MODE_NONE : 2'($urandom_range(0, 2));
          run_cmd(m, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  (r < 80) ? SDA_RAND : ((r < 90) ? SDA_LOW : SDA_HIGH), 1'($urandom));
        end
      end
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_long_half_period();
    set_half_period(16'd40);
    src_idle = 1'b0;
    sink_idle = 1'b0;
    run_cmd(i2cmbe_pkg::MODE_STOP, 8'h00, 1'b0, 1'b0, 1'b0, SDA_RAND, 1'b1);
    src_idle = 1'b1;
    sink_idle = 1'b1;
    set_half_period(i2cmbe_pkg::HALF_PERIOD_RESET);
    run_cmd(i2cmbe_pkg::MODE_WRITE, 8'hC6, 1'b1, 1'b0, 1'b0, SDA_RAND, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_directed_cmds();
    test_zero_half_period();
    test_random_traffic();
    test_long_half_period();
    s_axis_tvalid <= 1'b0;
    while (pending_bus_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d tick words, %0d commands taken, %0d result words checked",
             words_sent, cmds_taken, results_seen);
    $display("half periods 0 to 7 and 40 with random source gaps and sink stalls");
    if (mismatches == 0 && pending_bus_q.size() == 0) begin
      $display("PASS i2c_master_byte_engine_unit");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL i2c_master_byte_engine_unit");
    end
    $finish;
  end

endmodule
